>>> rtl/core/triangle_cull_stage_macros.svh
// ----------------------------------------------------------------------------
// triangle_cull_stage_macros.svh
// Assertion helpers shared by the triangle cull stage sources.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_CULL_STAGE_MACROS_SVH
`define TRIANGLE_CULL_STAGE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Types and constants of the triangle cull stage.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int COORD_BITS = 32;
  localparam int REG_BITS   = 32;
  // width used to compare w against the plane limits
  localparam int RNG_BITS   = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
  // edge differences carry one extra bit, products twice that
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;

  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDING_CCW = 2'd0,
    CFG_NEAR_W      = 2'd1,
    CFG_FAR_W       = 2'd2
  } cfg_idx_e;

  localparam logic                       WINDING_RST = 1'b1;
  localparam logic signed [REG_BITS-1:0] NEAR_W_RST  = 32'sd6554;
  localparam logic signed [REG_BITS-1:0] FAR_W_RST   = 32'sd6553600;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t w;
  } vertex_t;

  typedef struct packed {
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v0_w;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v1_w;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    coord_t v2_w;
  } tri_in_t;

  typedef struct packed {
    logic frustum_reject;
    logic depth_range_reject;
    logic front_facing;
  } cull_res_t;

  // per-vertex findings of one lane
  typedef struct packed {
    logic outside;
    logic range_bad;
  } lane_flags_t;

  // sign of the doubled signed area
  typedef struct packed {
    logic neg;
    logic zero;
  } area_flags_t;

endpackage

>>> rtl/core/triangle_cull_stage.sv
// ----------------------------------------------------------------------------
// triangle_cull_stage
// Frustum, w plane and facing tests on one clip-space triangle per clock.
// ----------------------------------------------------------------------------
//
//   channel   | signals                                   | direction
//   ----------+-------------------------------------------+----------
//   triangle  | start_i, busy_o, tri_i                    | in
//   result    | done_o, result_o                          | out
//   config    | cfg_valid_i, cfg_ready_o, cfg_index_i,    | in
//             | cfg_data_i                                |
//
// One triangle transfers every clock; busy_o stays low, the stage is fully
// pipelined. Each result passes in turn through the edge subtract, the two area
// multipliers and the area compare registers, then through the merge register.
// done_o marks a result for a single cycle; the receiver cannot stall. Reset
// clears the valid pipe and loads the register defaults.
// Configuration writes are always ready.
//
module triangle_cull_stage
  import tcs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  tri_in_t                 tri_i,
  output logic                    done_o,
  output cull_res_t               result_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [REG_BITS-1:0]     cfg_data_i
);

  `include "triangle_cull_stage_macros.svh"

  localparam int NUM_LANES = 3;
  localparam int DEPTH     = 4;

  logic                       winding_q;
  logic signed [REG_BITS-1:0] near_q, far_q;

  logic [DEPTH-1:0]           vld_d, vld_q;
  logic                       accept;

  vertex_t                    vtx     [NUM_LANES];
  lane_flags_t                lane_fl [NUM_LANES];
  lane_flags_t                fl_s2_q [NUM_LANES];
  lane_flags_t                fl_s3_q [NUM_LANES];
  area_flags_t                area;
  cull_res_t                  res_d, res_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      winding_q <= WINDING_RST;
      near_q    <= NEAR_W_RST;
      far_q     <= FAR_W_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WINDING_CCW: winding_q <= cfg_data_i[0];
        CFG_NEAR_W:      near_q    <= $signed(cfg_data_i);
        CFG_FAR_W:       far_q     <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Split the triangle into one vertex per lane.
  assign vtx[0] = '{x: tri_i.v0_x, y: tri_i.v0_y, z: tri_i.v0_z, w: tri_i.v0_w};
  assign vtx[1] = '{x: tri_i.v1_x, y: tri_i.v1_y, z: tri_i.v1_z, w: tri_i.v1_w};
  assign vtx[2] = '{x: tri_i.v2_x, y: tri_i.v2_y, z: tri_i.v2_z, w: tri_i.v2_w};

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    tcs_vertex_lane u_lane (
      .clk_i   (clk_i),
      .vtx_i   (vtx[g]),
      .near_i  (near_q),
      .far_i   (far_q),
      .flags_o (lane_fl[g])
    );
  end

  tcs_area u_area (
    .clk_i  (clk_i),
    .tri_i  (tri_i),
    .area_o (area)
  );

  // Hold lane findings until the area sign catches up.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      fl_s2_q[i] <= lane_fl[i];
      fl_s3_q[i] <= fl_s2_q[i];
    end
  end

  // Merge: reject on all lanes outside or any lane off the w planes;
  // zero area counts as front in both windings.
  always_comb begin
    res_d.frustum_reject     = 1'b1;
    res_d.depth_range_reject = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      res_d.frustum_reject     = res_d.frustum_reject && fl_s3_q[i].outside;
      res_d.depth_range_reject = res_d.depth_range_reject || fl_s3_q[i].range_bad;
    end
    res_d.front_facing = area.zero || (winding_q ? !area.neg : area.neg);
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Advance the valid marks along with the data.
  assign vld_d = {vld_q[DEPTH-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign done_o   = vld_q[DEPTH-1];
  assign result_o = res_q;

  `TCS_ASSERT_IMP(a_done_latency, done_o, $past(accept, DEPTH),
                  "result strobe without a transfer four cycles earlier")
  `TCS_ASSERT_NXT(a_zero_front, vld_q[DEPTH-2] && area.zero, result_o.front_facing,
                  "zero area triangle not reported front facing")
  `TCS_ASSERT_NXT(a_ccw_back, vld_q[DEPTH-2] && area.neg && winding_q,
                  !result_o.front_facing,
                  "negative area reported front in counter-clockwise mode")

endmodule

>>> rtl/core/tcs_vertex_lane.sv
// ----------------------------------------------------------------------------
// tcs_vertex_lane
// Per-vertex cube test and w plane test, one registered stage.
// ----------------------------------------------------------------------------
module tcs_vertex_lane
  import tcs_pkg::*;
(
  input  logic                       clk_i,
  input  vertex_t                    vtx_i,
  input  logic signed [REG_BITS-1:0] near_i,
  input  logic signed [REG_BITS-1:0] far_i,
  output lane_flags_t                flags_o
);

  logic [COORD_BITS-1:0]      mag_x, mag_y, mag_z, mag_w;
  logic signed [RNG_BITS-1:0] w_ext, near_ext, far_ext;
  lane_flags_t                flags_d, flags_q;

  // magnitude as unsigned: the most negative code maps to its true size
  assign mag_x = vtx_i.x[COORD_BITS-1] ? -vtx_i.x : vtx_i.x;
  assign mag_y = vtx_i.y[COORD_BITS-1] ? -vtx_i.y : vtx_i.y;
  assign mag_z = vtx_i.z[COORD_BITS-1] ? -vtx_i.z : vtx_i.z;
  assign mag_w = vtx_i.w[COORD_BITS-1] ? -vtx_i.w : vtx_i.w;

  assign w_ext    = RNG_BITS'(vtx_i.w);
  assign near_ext = RNG_BITS'(near_i);
  assign far_ext  = RNG_BITS'(far_i);

  always_comb begin
    // w of zero puts the vertex outside; a point on a face stays inside
    flags_d.outside   = (vtx_i.w == '0) || (mag_x > mag_w) || (mag_y > mag_w) ||
                        (mag_z > mag_w);
    flags_d.range_bad = (w_ext < near_ext) || (w_ext > far_ext);
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
  end

  assign flags_o = flags_q;

endmodule

>>> rtl/core/tcs_area.sv
// ----------------------------------------------------------------------------
// tcs_area
// Signed shoelace area sign over x and y, three registered stages.
// ----------------------------------------------------------------------------
module tcs_area
  import tcs_pkg::*;
(
  input  logic        clk_i,
  input  tri_in_t     tri_i,
  output area_flags_t area_o
);

  logic signed [DIFF_BITS-1:0] dx1_d, dy2_d, dy1_d, dx2_d;
  logic signed [DIFF_BITS-1:0] dx1_q, dy2_q, dy1_q, dx2_q;
  logic signed [PROD_BITS-1:0] p_d, q_d, p_q, q_q;
  area_flags_t                 area_d, area_q;

  // edge vectors from vertex 0, one bit wider so they never wrap
  assign dx1_d = DIFF_BITS'(tri_i.v1_x) - DIFF_BITS'(tri_i.v0_x);
  assign dy2_d = DIFF_BITS'(tri_i.v2_y) - DIFF_BITS'(tri_i.v0_y);
  assign dy1_d = DIFF_BITS'(tri_i.v1_y) - DIFF_BITS'(tri_i.v0_y);
  assign dx2_d = DIFF_BITS'(tri_i.v2_x) - DIFF_BITS'(tri_i.v0_x);

  assign p_d = PROD_BITS'(dx1_q) * PROD_BITS'(dy2_q);
  assign q_d = PROD_BITS'(dy1_q) * PROD_BITS'(dx2_q);

  always_comb begin
    area_d.neg  = (p_q < q_q);
    area_d.zero = (p_q == q_q);
  end

  always_ff @(posedge clk_i) begin
    dx1_q  <= dx1_d;
    dy2_q  <= dy2_d;
    dy1_q  <= dy1_d;
    dx2_q  <= dx2_d;
    p_q    <= p_d;
    q_q    <= q_d;
    area_q <= area_d;
  end

  assign area_o = area_q;

endmodule
